@@ rtl/i2p_pkg.sv @@
package i2p_pkg;

  localparam logic [7:0] CH_OPEN  = 8'h28;  // (
  localparam logic [7:0] CH_CLOSE = 8'h29;  // )
  localparam logic [7:0] CH_MUL   = 8'h2a;  // *
  localparam logic [7:0] CH_PLUS  = 8'h2b;  // +
  localparam logic [7:0] CH_MINUS = 8'h2d;  // -
  localparam logic [7:0] CH_DIV   = 8'h2f;  // /
  localparam logic [7:0] CH_POW   = 8'h5e;  // ^

  localparam logic [2:0] CODE_OPEN  = 3'd0;
  localparam logic [2:0] CODE_PLUS  = 3'd1;
  localparam logic [2:0] CODE_MINUS = 3'd2;
  localparam logic [2:0] CODE_MUL   = 3'd3;
  localparam logic [2:0] CODE_DIV   = 3'd4;
  localparam logic [2:0] CODE_POW   = 3'd5;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_CLOSE = 2'd1;
  localparam logic [1:0] ERR_OVF   = 2'd2;

  typedef enum logic [2:0] {
    CLS_ALNUM,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OP,
    CLS_OTHER
  } cls_e;

  typedef enum logic [1:0] {
    EM_CHAR,
    EM_TOP,
    EM_ERR_CLOSE,
    EM_ERR_OVF
  } emit_sel_e;

  typedef enum logic [1:0] {
    MODE_CLOSE,
    MODE_OP,
    MODE_FLUSH
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LOOP,
    ST_WAIT,
    ST_EXAM,
    ST_END
  } state_e;

  typedef struct packed {
    logic      latch;
    logic      emit;
    emit_sel_e emit_sel;
    logic      push;
    logic      pop;
    logic      fin;
  } cmd_t;

  typedef struct packed {
    cls_e cls;
    logic cnt_zero;
    logic full;
    logic top_open;
    logic top_pops;
    logic pend_valid;
    logic out_free;
    logic last;
  } sts_t;

  function automatic cls_e char_class(input logic [7:0] ch);
    cls_e c;
    c = CLS_OTHER;
    if (ch inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]}) begin
      c = CLS_ALNUM;
    end else if (ch == CH_OPEN) begin
      c = CLS_OPEN;
    end else if (ch == CH_CLOSE) begin
      c = CLS_CLOSE;
    end else if (ch inside {CH_PLUS, CH_MINUS, CH_MUL, CH_DIV, CH_POW}) begin
      c = CLS_OP;
    end
    return c;
  endfunction

  function automatic logic [2:0] code_of_char(input logic [7:0] ch);
    logic [2:0] c;
    case (ch)
      CH_PLUS:  c = CODE_PLUS;
      CH_MINUS: c = CODE_MINUS;
      CH_MUL:   c = CODE_MUL;
      CH_DIV:   c = CODE_DIV;
      CH_POW:   c = CODE_POW;
      default:  c = CODE_OPEN;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] char_of_code(input logic [2:0] code);
    logic [7:0] ch;
    case (code)
      CODE_OPEN:  ch = CH_OPEN;
      CODE_PLUS:  ch = CH_PLUS;
      CODE_MINUS: ch = CH_MINUS;
      CODE_MUL:   ch = CH_MUL;
      CODE_DIV:   ch = CH_DIV;
      CODE_POW:   ch = CH_POW;
      default:    ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [1:0] prec_of_code(input logic [2:0] code);
    logic [1:0] p;
    case (code)
      CODE_PLUS, CODE_MINUS: p = 2'd1;
      CODE_MUL, CODE_DIV:    p = 2'd2;
      CODE_POW:              p = 2'd3;
      default:               p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

@@ rtl/i2p_ram.sv @@
module i2p_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/i2p_ctrl.sv @@
module i2p_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  i2p_pkg::sts_t  sts_i,
  output i2p_pkg::cmd_t  cmd_o
);

  i2p_pkg::state_e state_q, state_d;
  i2p_pkg::mode_e  mode_q, mode_d;
  logic            emit_ok;
  logic            fin_ok;

  assign emit_ok = !sts_i.pend_valid || sts_i.out_free;
  assign fin_ok  = !(sts_i.pend_valid || sts_i.last) || sts_i.out_free;
  assign in_stall_o = (state_q != i2p_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= i2p_pkg::ST_IDLE;
      mode_q  <= i2p_pkg::MODE_FLUSH;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    cmd_o   = '0;
    cmd_o.emit_sel = i2p_pkg::EM_CHAR;
    case (state_q)
      i2p_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d = i2p_pkg::ST_DECODE;
        end
      end
      i2p_pkg::ST_DECODE: begin
        case (sts_i.cls)
          i2p_pkg::CLS_ALNUM: begin
            if (emit_ok) begin
              cmd_o.emit = 1'b1;
              cmd_o.emit_sel = i2p_pkg::EM_CHAR;
              state_d = i2p_pkg::ST_END;
            end
          end
          i2p_pkg::CLS_OPEN: begin
            if (!sts_i.full) begin
              cmd_o.push = 1'b1;
              state_d = i2p_pkg::ST_END;
            end else if (emit_ok) begin
              cmd_o.emit = 1'b1;
              cmd_o.emit_sel = i2p_pkg::EM_ERR_OVF;
              state_d = i2p_pkg::ST_END;
            end
          end
          i2p_pkg::CLS_CLOSE: begin
            mode_d  = i2p_pkg::MODE_CLOSE;
            state_d = i2p_pkg::ST_LOOP;
          end
          i2p_pkg::CLS_OP: begin
            mode_d  = i2p_pkg::MODE_OP;
            state_d = i2p_pkg::ST_LOOP;
          end
          default: begin
            state_d = i2p_pkg::ST_END;
          end
        endcase
      end
      i2p_pkg::ST_LOOP: begin
        if (!sts_i.cnt_zero) begin
          state_d = i2p_pkg::ST_WAIT;
        end else begin
          case (mode_q)
            i2p_pkg::MODE_CLOSE: begin
              if (emit_ok) begin
                cmd_o.emit = 1'b1;
                cmd_o.emit_sel = i2p_pkg::EM_ERR_CLOSE;
                state_d = i2p_pkg::ST_END;
              end
            end
            i2p_pkg::MODE_OP: begin
              cmd_o.push = 1'b1;
              state_d = i2p_pkg::ST_END;
            end
            default: begin
              state_d = i2p_pkg::ST_END;
            end
          endcase
        end
      end
      i2p_pkg::ST_WAIT: begin
        state_d = i2p_pkg::ST_EXAM;
      end
      i2p_pkg::ST_EXAM: begin
        case (mode_q)
          i2p_pkg::MODE_CLOSE: begin
            if (sts_i.top_open) begin
              cmd_o.pop = 1'b1;
              state_d = i2p_pkg::ST_END;
            end else if (emit_ok) begin
              cmd_o.pop  = 1'b1;
              cmd_o.emit = 1'b1;
              cmd_o.emit_sel = i2p_pkg::EM_TOP;
              state_d = i2p_pkg::ST_LOOP;
            end
          end
          i2p_pkg::MODE_OP: begin
            if (sts_i.top_open || !sts_i.top_pops) begin
              if (!sts_i.full) begin
                cmd_o.push = 1'b1;
                state_d = i2p_pkg::ST_END;
              end else if (emit_ok) begin
                cmd_o.emit = 1'b1;
                cmd_o.emit_sel = i2p_pkg::EM_ERR_OVF;
                state_d = i2p_pkg::ST_END;
              end
            end else if (emit_ok) begin
              cmd_o.pop  = 1'b1;
              cmd_o.emit = 1'b1;
              cmd_o.emit_sel = i2p_pkg::EM_TOP;
              state_d = i2p_pkg::ST_LOOP;
            end
          end
          default: begin
            if (sts_i.top_open) begin
              cmd_o.pop = 1'b1;
              state_d = i2p_pkg::ST_END;
            end else if (emit_ok) begin
              cmd_o.pop  = 1'b1;
              cmd_o.emit = 1'b1;
              cmd_o.emit_sel = i2p_pkg::EM_TOP;
              state_d = i2p_pkg::ST_END;
            end
          end
        endcase
      end
      i2p_pkg::ST_END: begin
        if (sts_i.last && !sts_i.cnt_zero) begin
          mode_d  = i2p_pkg::MODE_FLUSH;
          state_d = i2p_pkg::ST_WAIT;
        end else if (fin_ok) begin
          cmd_o.fin = 1'b1;
          state_d = i2p_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = i2p_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/i2p_dpath.sv @@
module i2p_dpath #(
  parameter int STACK_DEPTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    in_char_i,
  input  logic          in_last_i,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  output logic [7:0]    out_char_o,
  output logic          char_valid_o,
  output logic          out_last_o,
  output logic [1:0]    error_code_o,
  input  i2p_pkg::cmd_t cmd_i,
  output i2p_pkg::sts_t sts_o
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic [7:0]    char_q;
  logic          last_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] count_m1;
  logic [2:0]    top;
  logic [2:0]    in_code;
  logic [1:0]    in_prec;
  logic [1:0]    top_prec;

  // pending result, held back until it is known whether it closes the expression
  logic          pend_valid_q;
  logic [7:0]    pend_char_q;
  logic          pend_cv_q;
  logic [1:0]    pend_err_q;
  logic [7:0]    new_char;
  logic          new_cv;
  logic [1:0]    new_err;

  logic          out_valid_q;
  logic [7:0]    out_char_q;
  logic          out_cv_q;
  logic          out_last_q;
  logic [1:0]    out_err_q;
  logic          out_free;

  assign count_m1 = count_q - 1'b1;
  assign in_code  = i2p_pkg::code_of_char(char_q);
  assign in_prec  = i2p_pkg::prec_of_code(in_code);
  assign top_prec = i2p_pkg::prec_of_code(top);
  assign out_free = !out_valid_q || !out_stall_i;

  i2p_ram #(
    .WIDTH(3),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (cmd_i.push),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i(in_code),
    .raddr_i(count_m1[AW-1:0]),
    .rdata_o(top)
  );

  always_comb begin
    sts_o.cls        = i2p_pkg::char_class(char_q);
    sts_o.cnt_zero   = (count_q == '0);
    sts_o.full       = (count_q == CW'(STACK_DEPTH));
    sts_o.top_open   = (top == i2p_pkg::CODE_OPEN);
    sts_o.top_pops   = (top_prec > in_prec) ||
                       ((top_prec == in_prec) && (in_code != i2p_pkg::CODE_POW));
    sts_o.pend_valid = pend_valid_q;
    sts_o.out_free   = out_free;
    sts_o.last       = last_q;
  end

  always_comb begin
    new_char = 8'h00;
    new_cv   = 1'b0;
    new_err  = i2p_pkg::ERR_NONE;
    case (cmd_i.emit_sel)
      i2p_pkg::EM_CHAR: begin
        new_char = char_q;
        new_cv   = 1'b1;
      end
      i2p_pkg::EM_TOP: begin
        new_char = i2p_pkg::char_of_code(top);
        new_cv   = 1'b1;
      end
      i2p_pkg::EM_ERR_CLOSE: begin
        new_err = i2p_pkg::ERR_CLOSE;
      end
      default: begin
        new_err = i2p_pkg::ERR_OVF;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      char_q <= in_char_i;
      last_q <= in_last_i;
    end
    if (cmd_i.emit) begin
      pend_char_q <= new_char;
      pend_cv_q   <= new_cv;
      pend_err_q  <= new_err;
    end
    if (cmd_i.emit && pend_valid_q) begin
      out_char_q <= pend_char_q;
      out_cv_q   <= pend_cv_q;
      out_err_q  <= pend_err_q;
      out_last_q <= 1'b0;
    end else if (cmd_i.fin && pend_valid_q) begin
      out_char_q <= pend_char_q;
      out_cv_q   <= pend_cv_q;
      out_err_q  <= pend_err_q;
      out_last_q <= last_q;
    end else if (cmd_i.fin && last_q) begin
      out_char_q <= 8'h00;
      out_cv_q   <= 1'b0;
      out_err_q  <= i2p_pkg::ERR_NONE;
      out_last_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.push) begin
        count_q <= count_q + 1'b1;
      end else if (cmd_i.pop) begin
        count_q <= count_m1;
      end
      if (cmd_i.emit) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.fin) begin
        pend_valid_q <= 1'b0;
      end
      if ((cmd_i.emit && pend_valid_q) || (cmd_i.fin && (pend_valid_q || last_q))) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_char_o   = out_char_q;
  assign char_valid_o = out_cv_q;
  assign out_last_o   = out_last_q;
  assign error_code_o = out_err_q;

endmodule

@@ rtl/infix_to_postfix_converter_core.sv @@
// infix to postfix conversion with an operator stack
// input channel: in_valid_i / in_stall_o carry one character per item with in_last_i
// marking the end of an expression. output channel: out_valid_o / out_stall_i carry
// one postfix character or error indication per item; out_last_o marks the final item
// of an expression, an empty item with out_last_o is sent when nothing else is produced.
// one item is worked at a time: in_stall_o is high from acceptance until the item is done.
// a letter, digit, '(' or ignored character passes the decode and end states; an operator
// or ')' also runs the loop, wait and exam states for each stack entry examined, since
// each pop waits on the registered stack read.
// the end of an expression runs the wait and exam states per stacked entry for the flush.
// each result is held one step in a pending register so the last flag can be set, so a
// result leaves the block when the next one is made or when the item completes.
// out_stall_i high holds the output register; work stops when a result has no room.
// reset empties the stack and drops any pending or waiting output.
module infix_to_postfix_converter_core #(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_char_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       char_valid_o,
  output logic       out_last_o,
  output logic [1:0] error_code_o
);

  i2p_pkg::cmd_t cmd;
  i2p_pkg::sts_t sts;

  i2p_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  i2p_dpath #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_char_i   (in_char_i),
    .in_last_i   (in_last_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_char_o  (out_char_o),
    .char_valid_o(char_valid_o),
    .out_last_o  (out_last_o),
    .error_code_o(error_code_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
